[sv/mfrr_pkg.sv]
`default_nettype none
// ============================================================================
// mfrr_pkg
// Shared types and constants for the MIPS fragment relocation resolver.
// ============================================================================
package mfrr_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_SECTION_BASE = 2'd0;
    localparam logic [1:0] CFG_BODY_SIZE    = 2'd1;
    localparam logic [1:0] CFG_OWN_SECTION  = 2'd2;

    // raw entry type codes (entry bits 30:24)
    localparam logic [6:0] TYPE_ABS32 = 7'd2;
    localparam logic [6:0] TYPE_J26   = 7'd4;
    localparam logic [6:0] TYPE_HI16  = 7'd5;
    localparam logic [6:0] TYPE_LO16  = 7'd6;

    // result kinds
    localparam logic [1:0] KIND_ABS = 2'd0;
    localparam logic [1:0] KIND_JMP = 2'd1;
    localparam logic [1:0] KIND_HI  = 2'd2;
    localparam logic [1:0] KIND_LO  = 2'd3;

    // pair status
    localparam logic [1:0] ST_RESOLVED = 2'd0;
    localparam logic [1:0] ST_UNPAIRED = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // drain modes
    localparam logic [1:0] MODE_PAIR = 2'd0;
    localparam logic [1:0] MODE_OVF  = 2'd1;
    localparam logic [1:0] MODE_END  = 2'd2;

    localparam logic [24:0] WORD_BYTES = 25'd4;

    typedef struct packed {
        logic [31:0] entry_word;
        logic [31:0] insn_word;
        logic        table_end;
    } t_in_item;

    typedef struct packed {
        logic [31:0] reloc_address;
        logic [1:0]  reloc_kind;
        logic [31:0] target_offset;
        logic [15:0] tgt_section;
        logic [1:0]  pair_status;
        logic        abs32_present;
        logic        last_of_run;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [23:0] offset;
        logic [31:0] word;
    } t_hold_ent;

    // controller -> datapath
    typedef struct packed {
        logic       capture;
        logic       rd;
        logic       drain_done;
        logic       push;
        logic       emit;
        logic       emit_self;
        logic [1:0] mode;
        logic       last;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic ok;
        logic is_lo;
        logic is_hi;
        logic is_end;
        logic cnt_zero;
        logic cnt_full;
        logic idx_done;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

[sv/mfrr_ctrl.sv]
`default_nettype none
// ============================================================================
// mfrr_ctrl
// Sequencer: decides per entry whether to drain, hold or emit directly.
// ============================================================================
module mfrr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire mfrr_pkg::t_sts i_sts,
    output mfrr_pkg::t_cmd     o_cmd
);
    import mfrr_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_DRD    = 3'd2;
    localparam logic [2:0] S_DEM    = 3'd3;
    localparam logic [2:0] S_POST   = 3'd4;
    localparam logic [2:0] S_SELF   = 3'd5;

    logic [2:0] r_state, n_state;
    logic [1:0] r_mode, n_mode;
    logic       drain_last;

    assign o_in_ready = (r_state == S_IDLE);

    // last held entry ends the run unless something follows the drain
    always_comb begin
        unique case (r_mode)
            MODE_PAIR: drain_last = 1'b0;
            MODE_OVF:  drain_last = i_sts.is_hi && !i_sts.is_end;
            default:   drain_last = 1'b1;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        o_cmd     = '0;
        o_cmd.mode = r_mode;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.ok && i_sts.is_lo) begin
                    if (!i_sts.cnt_zero) begin
                        n_mode  = MODE_PAIR;
                        n_state = S_DRD;
                    end else begin
                        n_state = S_SELF;
                    end
                end else if (i_sts.ok) begin
                    if (i_sts.cnt_full) begin
                        n_mode  = MODE_OVF;
                        n_state = S_DRD;
                    end else if (i_sts.is_hi || !i_sts.cnt_zero) begin
                        o_cmd.push = 1'b1;
                        if (i_sts.is_end) begin
                            n_mode  = MODE_END;
                            n_state = S_DRD;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_state = S_SELF;
                    end
                end else if (i_sts.is_end && !i_sts.cnt_zero) begin
                    n_mode  = MODE_END;
                    n_state = S_DRD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DRD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_DEM;
            end
            S_DEM: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = i_sts.idx_done && drain_last;
                    if (i_sts.idx_done) begin
                        o_cmd.drain_done = 1'b1;
                        unique case (r_mode)
                            MODE_PAIR: n_state = S_SELF;
                            MODE_OVF:  n_state = S_POST;
                            default:   n_state = S_IDLE;
                        endcase
                    end else begin
                        n_state = S_DRD;
                    end
                end
            end
            S_POST: begin
                // buffer just emptied by overflow
                if (i_sts.is_hi) begin
                    o_cmd.push = 1'b1;
                    if (i_sts.is_end) begin
                        n_mode  = MODE_END;
                        n_state = S_DRD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_SELF;
                end
            end
            S_SELF: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_self = 1'b1;
                    o_cmd.last      = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= MODE_PAIR;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
        end
    end

endmodule
`default_nettype wire

[sv/mfrr_dpath.sv]
`default_nettype none
// ============================================================================
// mfrr_dpath
// Config registers, entry decode, hold buffer RAM and result register.
// ============================================================================
module mfrr_dpath #(
    parameter int HOLD_DEPTH = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [31:0]        i_cfg_data,
    input  wire mfrr_pkg::t_in_item i_in,
    input  wire mfrr_pkg::t_cmd     i_cmd,
    output mfrr_pkg::t_sts          o_sts,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output mfrr_pkg::t_out_item     o_out
);
    import mfrr_pkg::*;

    localparam int AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int CW = $clog2(HOLD_DEPTH + 1);

    // configuration
    logic [31:0] r_base;
    logic [24:0] r_body_size;
    logic [15:0] r_own;

    // captured entry
    logic        r_ok;
    logic [1:0]  r_kind;
    logic [23:0] r_off;
    logic [31:0] r_word;
    logic        r_end;
    logic [31:0] r_lo_adj;   // sext(lo16) - base

    // hold buffer and tracking
    t_hold_ent   r_mem [HOLD_DEPTH];
    t_hold_ent   r_rd;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_idx;
    logic [15:0] r_hi_half;
    logic        r_hi_seen;
    logic        r_abs;

    // decode of the incoming entry
    logic [6:0]  in_type;
    logic [23:0] in_off;
    logic        in_known;
    logic [1:0]  in_kind;
    logic        in_fits;

    assign in_type = i_in.entry_word[30:24];
    assign in_off  = i_in.entry_word[23:0];
    assign in_fits = ({1'b0, in_off} + WORD_BYTES) <= r_body_size;

    always_comb begin
        in_known = 1'b1;
        in_kind  = KIND_ABS;
        unique case (in_type)
            TYPE_ABS32: in_kind = KIND_ABS;
            TYPE_J26:   in_kind = KIND_JMP;
            TYPE_HI16:  in_kind = KIND_HI;
            TYPE_LO16:  in_kind = KIND_LO;
            default:    in_known = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_body_size <= '0;
            r_own       <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SECTION_BASE: r_base      <= i_cfg_data;
                CFG_BODY_SIZE:    r_body_size <= i_cfg_data[24:0];
                CFG_OWN_SECTION:  r_own       <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ok     <= in_known && in_fits;
            r_kind   <= in_kind;
            r_off    <= in_off;
            r_word   <= i_in.insn_word;
            r_end    <= i_in.table_end;
            r_lo_adj <= {{16{i_in.insn_word[15]}}, i_in.insn_word[15:0]} - r_base;
        end
    end

    // hold buffer RAM: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_cnt[AW-1:0]] <= '{kind: r_kind, offset: r_off, word: r_word};
        end
        if (i_cmd.rd) begin
            r_rd <= r_mem[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_idx     <= '0;
            r_hi_half <= '0;
            r_hi_seen <= 1'b0;
        end else begin
            if (i_cmd.drain_done) begin
                r_cnt <= '0;
                r_idx <= '0;
            end else begin
                if (i_cmd.push) r_cnt <= r_cnt + CW'(1);
                if (i_cmd.rd)   r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.push && (r_kind == KIND_HI)) begin
                r_hi_half <= r_word[15:0];
                r_hi_seen <= 1'b1;
            end
        end
    end

    assign o_sts.ok       = r_ok;
    assign o_sts.is_lo    = (r_kind == KIND_LO);
    assign o_sts.is_hi    = (r_kind == KIND_HI);
    assign o_sts.is_end   = r_end;
    assign o_sts.cnt_zero = (r_cnt == '0);
    assign o_sts.cnt_full = (r_cnt == CW'(HOLD_DEPTH));
    assign o_sts.idx_done = (r_idx == r_cnt);
    assign o_sts.out_free = !o_out_valid || i_out_ready;

    // result formation
    logic [1:0]  src_kind;
    logic [23:0] src_off;
    logic [31:0] src_word;
    logic [15:0] hi16;
    logic [31:0] pair_sum;
    logic [31:0] solo_tgt;
    logic [31:0] tgt;
    logic [1:0]  status;
    logic        abs_next;

    assign src_kind = i_cmd.emit_self ? r_kind : r_rd.kind;
    assign src_off  = i_cmd.emit_self ? r_off  : r_rd.offset;
    assign src_word = i_cmd.emit_self ? r_word : r_rd.word;
    assign hi16     = i_cmd.emit_self ? r_hi_half : src_word[15:0];
    assign pair_sum = {hi16, 16'h0000} + r_lo_adj;
    assign solo_tgt = ((src_kind == KIND_ABS) ? src_word
                       : {r_base[31:28], src_word[25:0], 2'b00}) - r_base;
    assign abs_next = r_abs || (src_kind == KIND_ABS);

    always_comb begin
        tgt    = solo_tgt;
        status = ST_RESOLVED;
        if (i_cmd.emit_self) begin
            if (src_kind == KIND_LO) begin
                tgt    = r_hi_seen ? pair_sum : '0;
                status = r_hi_seen ? ST_RESOLVED : ST_UNPAIRED;
            end
        end else if (src_kind == KIND_HI) begin
            unique case (i_cmd.mode)
                MODE_PAIR: begin
                    tgt    = pair_sum;
                    status = ST_RESOLVED;
                end
                MODE_OVF: begin
                    tgt    = '0;
                    status = ST_OVERFLOW;
                end
                default: begin
                    tgt    = '0;
                    status = ST_UNPAIRED;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
            r_abs       <= 1'b0;
        end else if (i_cmd.emit) begin
            o_out_valid <= 1'b1;
            r_abs       <= abs_next;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_out.reloc_address <= r_base + {8'h00, src_off};
            o_out.reloc_kind    <= src_kind;
            o_out.target_offset <= tgt;
            o_out.tgt_section   <= r_own;
            o_out.pair_status   <= status;
            o_out.abs32_present <= abs_next;
            o_out.last_of_run   <= i_cmd.last;
        end
    end

endmodule
`default_nettype wire

[sv/mips_fragment_reloc_resolver_core.sv]
`default_nettype none
// Flow: an ABS32/J26/LO16 with an empty hold buffer is captured, decided and
//   emitted via the result register; a held HI16 (or one queued behind) waits for a drain.
// Entries: a new entry is taken only when the last one is done; each held entry drained
//   is a buffer read, then an emit; an overflow flush adds a post step. Sink stalls add more.
// Reset: synchronous active-low; clears config, buffer count, last HI16 and the
//   ABS32 flag. Buffer contents are not cleared (only filled slots are read).
// ============================================================================
// mips_fragment_reloc_resolver_core
// Resolves MIPS ABS32/J26/HI16/LO16 relocation entries, pairing HI16 with
// the next LO16 and preserving table order through a hold buffer.
// ============================================================================
module mips_fragment_reloc_resolver_core #(
    parameter int HOLD_DEPTH = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // config write port
    input  wire logic                i_cfg_we,
    input  wire logic [1:0]          i_cfg_idx,
    input  wire logic [31:0]         i_cfg_data,
    // entry channel
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire mfrr_pkg::t_in_item  i_in,
    // result channel
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output mfrr_pkg::t_out_item      o_out
);
    import mfrr_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Controller: one entry in flight. Each beat goes through a single
    // result register; the next held entry can be read while the sink stalls.
    mfrr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath: decode, hold buffer RAM (HOLD_DEPTH x 58b), target math.
    // HI16 pairs use sext(lo)-base precomputed at capture, so each
    // result needs just one 32-bit add on the emit path.
    mfrr_dpath #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire

[tb/sv/mfrr_reloc_sb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mfrr_reloc_sb_pkg
// Expected-result tracking for the relocation resolver: an in-order model
// of the hold buffer and HI16/LO16 pairing, and a field-by-field checker.
// ============================================================================
package mfrr_reloc_sb_pkg;

    import mfrr_pkg::*;

    localparam int HOLD_SLOTS = 8;

    class reloc_scoreboard;

        // register copies
        logic [31:0] base;
        logic [24:0] body;
        logic [15:0] own;

        // pairing state
        t_hold_ent   held [HOLD_SLOTS];
        int          held_n;
        logic [15:0] last_hi;
        bit          hi_seen;
        bit          abs_seen;

        t_out_item   due_q [$];
        int unsigned mismatches;
        int unsigned beats;

        function new();
            base       = '0;
            body       = '0;
            own        = '0;
            held_n     = 0;
            last_hi    = '0;
            hi_seen    = 1'b0;
            abs_seen   = 1'b0;
            mismatches = 0;
            beats      = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                CFG_SECTION_BASE: base = val;
                CFG_BODY_SIZE:    body = val[24:0];
                CFG_OWN_SECTION:  own  = val[15:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        // (hi << 16) + sext(lo) - base
        function logic [31:0] pair_target(logic [15:0] hi, logic [31:0] lo);
            return {hi, 16'h0000} + {{16{lo[15]}}, lo[15:0]} - base;
        endfunction

        function logic [31:0] solo_target(logic [1:0] kind, logic [31:0] word);
            if (kind == KIND_ABS)
                return word - base;
            return ((base & 32'hF000_0000) | {word[25:0], 2'b00}) - base;
        endfunction

        function void add_result(logic [1:0] kind, logic [23:0] off,
                                 logic [31:0] target, logic [1:0] status);
            t_out_item r;
            if (kind == KIND_ABS)
                abs_seen = 1'b1;
            r.reloc_address = base + {8'd0, off};
            r.reloc_kind    = kind;
            r.target_offset = target;
            r.tgt_section   = own;
            r.pair_status   = status;
            r.abs32_present = abs_seen;
            r.last_of_run   = 1'b0;
            due_q.insert(due_q.size(), r);
        endfunction

        // empty the buffer in order; HI16 halves lose their target
        function void flush_held(logic [1:0] hi_status);
            int i;
            for (i = 0; i < held_n; i++) begin
                if (held[i].kind == KIND_HI)
                    add_result(KIND_HI, held[i].offset, 32'd0, hi_status);
                else
                    add_result(held[i].kind, held[i].offset,
                               solo_target(held[i].kind, held[i].word), ST_RESOLVED);
            end
            held_n = 0;
        endfunction

        // one accepted table entry -> zero or more expected beats
        function void resolve_entry(t_in_item it);
            logic [6:0]  code;
            logic [23:0] off;
            logic [31:0] word;
            logic [1:0]  kind;
            bit          ok;
            int          first;
            int          i;
            first = due_q.size();
            code  = it.entry_word[30:24];
            off   = it.entry_word[23:0];
            word  = it.insn_word;
            ok    = 1'b1;
            kind  = KIND_ABS;
            case (code)
                TYPE_ABS32: kind = KIND_ABS;
                TYPE_J26:   kind = KIND_JMP;
                TYPE_HI16:  kind = KIND_HI;
                TYPE_LO16:  kind = KIND_LO;
                default:    ok = 1'b0;
            endcase
            if (({8'd0, off} + 32'd4) > {7'd0, body})
                ok = 1'b0;

            if (ok && kind == KIND_LO) begin
                for (i = 0; i < held_n; i++) begin
                    if (held[i].kind == KIND_HI)
                        add_result(KIND_HI, held[i].offset,
                                   pair_target(held[i].word[15:0], word), ST_RESOLVED);
                    else
                        add_result(held[i].kind, held[i].offset,
                                   solo_target(held[i].kind, held[i].word), ST_RESOLVED);
                end
                held_n = 0;
                if (hi_seen)
                    add_result(KIND_LO, off, pair_target(last_hi, word), ST_RESOLVED);
                else
                    add_result(KIND_LO, off, 32'd0, ST_UNPAIRED);
            end else if (ok) begin
                if (held_n >= HOLD_SLOTS)
                    flush_held(ST_OVERFLOW);
                if (kind == KIND_HI) begin
                    last_hi = word[15:0];
                    hi_seen = 1'b1;
                end
                if (kind == KIND_HI || held_n > 0) begin
                    held[held_n].kind   = kind;
                    held[held_n].offset = off;
                    held[held_n].word   = word;
                    held_n++;
                end else begin
                    add_result(kind, off, solo_target(kind, word), ST_RESOLVED);
                end
            end

            if (it.table_end && held_n > 0)
                flush_held(ST_UNPAIRED);
            if (due_q.size() > first)
                due_q[due_q.size() - 1].last_of_run = 1'b1;
        endfunction

        function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_reloc(t_out_item got);
            t_out_item want;
            beats++;
            if (due_q.size() == 0) begin
                $error("unexpected result beat: reloc_address %0h kind %0d",
                       got.reloc_address, got.reloc_kind);
                mismatches++;
                return;
            end
            want = due_q.pop_front();
            cmp_field("reloc_address", want.reloc_address, got.reloc_address);
            cmp_field("reloc_kind", 32'(want.reloc_kind), 32'(got.reloc_kind));
            cmp_field("target_offset", want.target_offset, got.target_offset);
            cmp_field("target_section", 32'(want.tgt_section), 32'(got.tgt_section));
            cmp_field("pair_status", 32'(want.pair_status), 32'(got.pair_status));
            cmp_field("abs32_present", 32'(want.abs32_present), 32'(got.abs32_present));
            cmp_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
        endfunction

    endclass

endpackage
`default_nettype wire

[tb/sv/tb_mips_fragment_reloc_resolver_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// tb_mips_fragment_reloc_resolver_core
// Streams relocation entries through the resolver under random backpressure
// and compares every result beat against an in-order pairing model.
// ============================================================================
module tb_mips_fragment_reloc_resolver_core;

    import mfrr_pkg::*;
    import mfrr_reloc_sb_pkg::*;

    localparam int          DRAIN_GAP  = 24;       // quiet time after the last expected beat
    localparam int unsigned CYCLE_CAP  = 400000;
    localparam int          STALL_LEN  = 300;      // long receiver hold-off, in cycles
    localparam int          IDLE_PCT   = 38;
    localparam int          PHASE_ITEMS = 72;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_idx = CFG_SECTION_BASE;
    logic [31:0] cfg_data = '0;

    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in_item    in_beat = '0;

    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_item   out_beat;

    reloc_scoreboard sb;

    // sequencing flags shared by the driver and the sink
    bit          quiet = 1'b0;      // no idling on either side
    bit          stall_req = 1'b0;  // ask the sink for one long hold-off
    int          stall_left = 0;

    int unsigned cur_body = 0;      // body size as last written, for offset picking
    int unsigned entries = 0;       // every accepted entry
    int unsigned live = 0;          // accepted entries of known type inside the body
    int unsigned settings = 0;
    int unsigned cycles = 0;

    mips_fragment_reloc_resolver_core #(
        .HOLD_DEPTH (HOLD_SLOTS)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_beat)
    );

    // 4 ns clock
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog: a run that stops making progress ends as a failure.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_CAP) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result side. Ready changes at the falling edge; a beat is taken at the
    // rising edge where valid and ready are both high. One long hold-off is
    // counted here when the driver asks for it, so the hold buffer and the
    // output stage fill and the entry channel has to stall.
    // ------------------------------------------------------------------------
    initial begin
        forever begin
            @(negedge clk);
            if (stall_req) begin
                stall_req  = 1'b0;
                stall_left = STALL_LEN;
            end
            if (stall_left > 0) begin
                out_ready  <= 1'b0;
                stall_left = stall_left - 1;
            end else begin
                out_ready <= quiet || ($urandom_range(99, 0) >= IDLE_PCT);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            sb.check_reloc(out_beat);
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers. Every task starts and ends on a falling edge.
    // ------------------------------------------------------------------------
    function automatic bit known_code(logic [6:0] code);
        return code == TYPE_ABS32 || code == TYPE_J26 ||
               code == TYPE_HI16  || code == TYPE_LO16;
    endfunction

    function automatic logic [6:0] junk_code();
        logic [6:0] code;
        do
            code = 7'($urandom);
        while (known_code(code));
        return code;
    endfunction

    function automatic logic [6:0] filler_code();
        return $urandom_range(1, 0) ? TYPE_ABS32 : TYPE_J26;
    endfunction

    // Mostly offsets that fit, with the last fitting word and the first
    // one past the body hit on purpose.
    function automatic logic [23:0] pick_offset();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (cur_body < 4 || r < 4)
            return 24'($urandom);
        if (r < 10)
            return 24'(cur_body - 4);
        if (r < 13)
            return 24'(cur_body - 3);
        return 24'($urandom_range(cur_body - 4, 0));
    endfunction

    // One beat on the entry channel; bit 31 of the entry is don't-care and
    // gets a random value.
    task automatic push_entry(input logic [6:0] code, input logic [23:0] off,
                              input logic [31:0] word, input logic last);
        t_in_item it;
        it.entry_word = {1'($urandom), code, off};
        it.insn_word  = word;
        it.table_end  = last;
        while (!quiet && $urandom_range(99, 0) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.resolve_entry(it);
        entries++;
        if (known_code(code) && ({8'd0, off} + 32'd4) <= cur_body)
            live++;
        @(negedge clk);
    endtask

    // Stop offering, wait for every expected beat, then let the block go
    // quiet (dropped or held entries leave no beat to wait for).
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_GAP) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        sb.set_reg(idx, val);
        @(negedge clk);
    endtask

    task automatic write_regs(input logic [31:0] base, input logic [31:0] size,
                              input logic [31:0] own);
        cfg_write(CFG_SECTION_BASE, base);
        cfg_write(CFG_BODY_SIZE, size);
        cfg_write(CFG_OWN_SECTION, own);
        cfg_we   <= 1'b0;
        cur_body = size;
        settings++;
        @(negedge clk);
    endtask

    // One random burst: mostly HI16 runs closed by a LO16, some overflow
    // runs, lone entries, noise and runs cut short by the table end.
    task automatic random_group();
        int unsigned roll;
        int unsigned n;
        int unsigned k;
        roll = $urandom_range(99, 0);
        if (roll < 55) begin
            // HI16, a few HI16/fillers queued behind it, then the LO16
            n = $urandom_range(5, 0);
            push_entry(TYPE_HI16, pick_offset(), $urandom, 1'b0);
            for (k = 0; k < n; k++)
                push_entry(($urandom_range(99, 0) < 30) ? TYPE_HI16 : filler_code(),
                           pick_offset(), $urandom, 1'b0);
            push_entry(TYPE_LO16, pick_offset(), $urandom, $urandom_range(99, 0) < 10);
        end else if (roll < 67) begin
            // more than the buffer holds before the LO16 shows up
            n = $urandom_range(10, 8);
            push_entry(TYPE_HI16, pick_offset(), $urandom, 1'b0);
            for (k = 0; k < n; k++)
                push_entry(($urandom_range(99, 0) < 25) ? TYPE_HI16 : filler_code(),
                           pick_offset(), $urandom, 1'b0);
            push_entry(TYPE_LO16, pick_offset(), $urandom, 1'b0);
        end else if (roll < 82) begin
            push_entry(($urandom_range(2, 0) == 0) ? TYPE_LO16 : filler_code(),
                       pick_offset(), $urandom, $urandom_range(99, 0) < 5);
        end else if (roll < 92) begin
            if ($urandom_range(1, 0))
                push_entry(junk_code(), pick_offset(), $urandom,
                           $urandom_range(99, 0) < 20);
            else
                push_entry(filler_code(), 24'($urandom), $urandom,
                           $urandom_range(99, 0) < 20);
        end else begin
            // HI16 never paired: the table ends first
            n = $urandom_range(3, 0);
            push_entry(TYPE_HI16, pick_offset(), $urandom, 1'b0);
            for (k = 0; k < n; k++)
                push_entry(filler_code(), pick_offset(), $urandom, 1'b0);
            push_entry($urandom_range(1, 0) ? junk_code() : filler_code(),
                       pick_offset(), $urandom, 1'b1);
        end
    endtask

    // One register setting followed by random traffic. Each phase closes
    // with a table end so nothing is left held across a register write.
    task automatic run_phase(input logic [31:0] base, input logic [31:0] size,
                             input logic [31:0] own, input bit no_idle,
                             input bit long_stall);
        int unsigned goal;
        write_regs(base, size, own);
        quiet = no_idle;
        if (long_stall)
            stall_req = 1'b1;
        goal = live + PHASE_ITEMS;
        while (live < goal) begin
            random_group();
            if ($urandom_range(99, 0) < 3)
                settle();
        end
        push_entry(junk_code(), 24'($urandom), $urandom, 1'b1);
        settle();
        quiet = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        sb = new();
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // registers still at reset: zero body size drops everything
        push_entry(TYPE_ABS32, 24'h000000, 32'hDEAD_BEEF, 1'b0);
        push_entry(TYPE_HI16, 24'h000000, 32'h0000_1234, 1'b0);
        push_entry(TYPE_LO16, 24'h000000, 32'h0000_5678, 1'b1);
        settle();

        // directed: base with high bits set, full body, all-ones section
        write_regs(32'h8000_0010, 32'd16777216, 32'h0000_FFFF);
        // LO16 before any HI16 was seen
        push_entry(TYPE_LO16, 24'h000100, 32'h1234_8000, 1'b0);
        // lone ABS32 / J26 at the body edges
        push_entry(TYPE_ABS32, 24'h000000, 32'hFFFF_FFFF, 1'b0);
        push_entry(TYPE_J26, 24'hFFFFFC, 32'hFFFF_FFFF, 1'b0);
        // word straddles the end of the body
        push_entry(TYPE_ABS32, 24'hFFFFFD, 32'h0000_0001, 1'b0);
        // unknown types, one of them closing the table with nothing held
        push_entry(7'h7F, 24'h000000, 32'h0, 1'b1);
        push_entry(7'h00, 24'h000004, 32'h0, 1'b0);
        // HI16 with entries queued behind it, released by a negative LO16
        push_entry(TYPE_HI16, 24'h000010, 32'h0000_FFFF, 1'b0);
        push_entry(TYPE_ABS32, 24'h000014, 32'h0000_0001, 1'b0);
        push_entry(TYPE_J26, 24'h000018, 32'h03FF_FFFF, 1'b0);
        push_entry(TYPE_LO16, 24'h00001C, 32'h0000_8000, 1'b0);
        // LO16 with nothing held reuses the last HI16
        push_entry(TYPE_LO16, 24'h000020, 32'h0000_7FFF, 1'b0);
        // table end on a resolvable entry flushes two lone HI16s
        push_entry(TYPE_HI16, 24'h000024, 32'hFFFF_0000, 1'b0);
        push_entry(TYPE_HI16, 24'h000028, 32'h0000_8000, 1'b0);
        push_entry(TYPE_J26, 24'h00002C, 32'h0000_0000, 1'b1);
        // table end on a dropped entry still flushes
        push_entry(TYPE_HI16, 24'h000030, 32'h0000_0001, 1'b0);
        push_entry(7'h01, 24'h000034, 32'h0, 1'b1);
        // fill the buffer; the next entry overflows it (nine beats at once)
        push_entry(TYPE_HI16, 24'h000040, 32'h0000_ABCD, 1'b0);
        repeat (7)
            push_entry(TYPE_ABS32, 24'h000044, $urandom, 1'b0);
        push_entry(TYPE_J26, 24'h000060, 32'hFC00_0000, 1'b0);
        settle();

        // random phases through the register extremes
        run_phase(32'h0000_0000, 32'd16777216, 32'h0000_0000, 1'b1, 1'b0);
        run_phase(32'hFFFF_FFFF, 32'd16777216, 32'h0000_FFFF, 1'b0, 1'b1);
        run_phase($urandom, 32'd256, $urandom_range(65535, 0), 1'b0, 1'b0);
        run_phase($urandom, $urandom_range(16777216, 4), $urandom_range(65535, 0),
                  1'b0, 1'b0);
        run_phase($urandom, 32'd16777216, $urandom_range(65535, 0), 1'b0, 1'b0);

        $display("covered %0d table entries (%0d resolvable) over %0d register settings",
                 entries, live, settings);
        $display("checked %0d result beats, including overflow and unpaired flushes",
                 sb.beats);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
`default_nettype wire
